@@ hdl/bba_pkg.sv @@
`default_nettype none

package bba_pkg;

  // Default depth of the block tree below the root.
  localparam int unsigned LevelsDef = 10;

  // Fixed field widths.
  localparam int unsigned OffW  = 40;
  localparam int unsigned SizeW = 41;
  localparam int unsigned CfgW  = 6;
  localparam int unsigned StatW = 2;
  // A rounded request is at most size + alignment - 1, which needs one more bit; two are kept.
  localparam int unsigned RealW = SizeW + 2;

  localparam logic [CfgW-1:0] PoolLog2Min = 6'd10;
  localparam logic [CfgW-1:0] PoolLog2Max = 6'd40;
  localparam logic [CfgW-1:0] PoolLog2Rst = 6'd20;

  typedef enum logic [1:0] {
    NODE_UNUSED = 2'd0,
    NODE_FREE   = 2'd1,
    NODE_ALLOC  = 2'd2,
    NODE_SPLIT  = 2'd3
  } node_e;

  typedef enum logic [StatW-1:0] {
    RES_OK       = 2'd0,
    RES_NO_SPACE = 2'd1,
    RES_BAD_FREE = 2'd2
  } res_e;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CLR_STEP,
    CMD_LOAD,
    CMD_REM_START,
    CMD_ROUND,
    CMD_K_INC,
    CMD_SET_D,
    CMD_RD_SCAN,
    CMD_SCAN_INC,
    CMD_NEXT_DEPTH,
    CMD_HIT,
    CMD_WR_SPLIT,
    CMD_WR_LEFT,
    CMD_WR_RIGHT,
    CMD_WR_ALLOC,
    CMD_FAIL_ALLOC,
    CMD_F_INIT,
    CMD_RD_NODE,
    CMD_DESCEND,
    CMD_WR_FREED,
    CMD_RD_BUDDY,
    CMD_WR_NODE_UNUSED,
    CMD_WR_BUDDY_UNUSED,
    CMD_WR_PARENT,
    CMD_FAIL_FREE,
    CMD_OK_FREE,
    CMD_PUSH
  } cmd_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_REM_START,
    S_REM_WAIT,
    S_LOG,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SPLIT0,
    S_SPLIT1,
    S_SPLIT2,
    S_ALLOC,
    S_F_INIT,
    S_F_RD,
    S_F_CHK,
    S_M_TOP,
    S_M_CHK,
    S_M_W1,
    S_M_W2,
    S_PUSH
  } state_e;

  typedef struct packed {
    cmd_e cmd;
    logic req_ready;
  } dp_ctrl_t;

  typedef struct packed {
    logic cfg_we;
    logic req_valid;
    logic op_free;
    logic rem_busy;
    logic k_step;
    logic k_fail;
    logic rd_free;
    logic rd_split;
    logic rd_alloc;
    logic scan_last;
    logic dd_zero;
    logic dd_eq_d;
    logic dd_next_eq_d;
    logic dd_lt_depth;
    logic off_oob;
    logic off_match;
    logic node_root;
    logic clr_last;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/bba_req_if.sv @@
`default_nettype none

interface bba_req_if;
  import bba_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [SizeW-1:0] request_size;
  logic [SizeW-1:0] alignment;
  logic [OffW-1:0]  free_offset;

  modport source (output valid, output opcode, output request_size, output alignment,
                  output free_offset, input ready);
  modport sink (input valid, input opcode, input request_size, input alignment,
                input free_offset, output ready);
endinterface

`default_nettype wire

@@ hdl/bba_rsp_if.sv @@
`default_nettype none

interface bba_rsp_if;
  import bba_pkg::*;

  logic             valid;
  logic             ready;
  logic [OffW-1:0]  block_offset;
  logic [StatW-1:0] status;

  modport source (output valid, output block_offset, output status, input ready);
  modport sink (input valid, input block_offset, input status, output ready);
endinterface

`default_nettype wire

@@ hdl/bba_rem_unit.sv @@
`default_nettype none

module bba_rem_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bba_pkg::SizeW-1:0] dividend_i,
  input  logic [bba_pkg::SizeW-1:0] divisor_i,
  output logic                      busy_o,
  output logic [bba_pkg::SizeW-1:0] rem_o
);
  import bba_pkg::*;

  localparam int unsigned CntW = $clog2(SizeW + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [SizeW-1:0] rem_q, rem_d;
  logic [SizeW-1:0] dvd_q, dvd_d;
  logic [SizeW-1:0] dvs_q, dvs_d;
  logic [SizeW:0]   trial;

  // Restoring remainder: one dividend bit per cycle, MSB first.
  always_comb begin
    trial  = {rem_q, dvd_q[SizeW-1]};
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d  = CntW'(SizeW);
      busy_d = 1'b1;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        trial = trial - {1'b0, dvs_q};
      end
      rem_d = trial[SizeW-1:0];
      dvd_d = {dvd_q[SizeW-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ hdl/bba_datapath.sv @@
`default_nettype none

module bba_datapath #(
  parameter int unsigned LEVELS = bba_pkg::LevelsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bba_pkg::CfgW-1:0] cfg_wdata_i,
  bba_req_if.sink                  req_i,
  bba_rsp_if.source                rsp_o,
  input  bba_pkg::dp_ctrl_t        ctrl_i,
  output bba_pkg::dp_status_t      status_o
);
  import bba_pkg::*;

  localparam int unsigned NodeW     = LEVELS + 1;
  localparam int unsigned NodeCount = (2 ** NodeW) - 1;
  localparam int unsigned DepthW    = $clog2(LEVELS + 1);

  function automatic logic [NodeW-1:0] level_first(input logic [DepthW-1:0] lv);
    level_first = (NodeW'(1) << lv) - NodeW'(1);
  endfunction

  // Tree memory, heap order.
  logic [1:0] tree_mem_q [NodeCount];
  node_e      rd_data_q;

  logic [CfgW-1:0]   pool_log2_q, pool_log2_d;
  logic [NodeW-1:0]  clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  logic [OffW-1:0]   out_off_q;
  res_e              out_st_q;

  logic              op_free_q;
  logic [SizeW-1:0]  size_q;
  logic [SizeW-1:0]  align_q;
  logic [OffW-1:0]   free_off_q;
  logic [RealW-1:0]  real_q;
  logic [CfgW-1:0]   k_q;
  logic [DepthW-1:0] d_q;
  logic [DepthW-1:0] dd_q;
  logic [NodeW-1:0]  node_q;
  logic [NodeW-1:0]  scan_q;
  logic [OffW-1:0]   res_off_q;
  res_e              res_st_q;

  logic              mem_we;
  logic [NodeW-1:0]  mem_waddr;
  node_e             mem_wdata;
  logic              mem_re;
  logic [NodeW-1:0]  mem_raddr;

  logic [CfgW-1:0]       depth6, minlog, dd6, cfg_sat, sh, bidx;
  logic [DepthW-1:0]     depth, d_new;
  logic [NodeW-1:0]      first_dd, last_dd, left, right, buddy, parent, pos;
  logic [OffW+NodeW-1:0] shifted;
  logic [OffW-1:0]       node_off;
  logic [RealW-1:0]      pow, round_val;
  logic                  rem_busy;
  logic [SizeW-1:0]      rem;
  cmd_e                  cmd;

  assign cmd = ctrl_i.cmd;

  bba_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd == CMD_REM_START),
    .dividend_i (size_q),
    .divisor_i  (align_q),
    .busy_o     (rem_busy),
    .rem_o      (rem)
  );

  always_comb begin
    depth6    = (CfgW'(LEVELS) < pool_log2_q) ? CfgW'(LEVELS) : pool_log2_q;
    depth     = depth6[DepthW-1:0];
    minlog    = pool_log2_q - depth6;
    dd6       = CfgW'(dd_q);
    d_new     = DepthW'(pool_log2_q - k_q);
    first_dd  = level_first(dd_q);
    last_dd   = {first_dd[NodeW-2:0], 1'b0};
    left      = {node_q[NodeW-2:0], 1'b1};
    right     = left + NodeW'(1);
    buddy     = node_q[0] ? node_q + NodeW'(1) : node_q - NodeW'(1);
    parent    = (node_q - NodeW'(1)) >> 1;
    pos       = node_q + NodeW'(1) - (NodeW'(1) << dd_q);
    sh        = pool_log2_q - dd6;
    shifted   = (OffW + NodeW)'(pos) << sh;
    node_off  = shifted[OffW-1:0];
    bidx      = pool_log2_q - dd6 - CfgW'(1);
    pow       = RealW'(1) << k_q;
    round_val = (rem == '0) ? RealW'(size_q)
                            : RealW'(size_q) + RealW'(align_q) - RealW'(rem);
    if (cfg_wdata_i < PoolLog2Min) begin
      cfg_sat = PoolLog2Min;
    end else if (cfg_wdata_i > PoolLog2Max) begin
      cfg_sat = PoolLog2Max;
    end else begin
      cfg_sat = cfg_wdata_i;
    end
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node_q;
    mem_wdata = NODE_UNUSED;
    mem_re    = 1'b0;
    mem_raddr = node_q;
    unique case (cmd)
      CMD_CLR_STEP: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = (clr_q == '0) ? NODE_FREE : NODE_UNUSED;
      end
      CMD_WR_SPLIT: begin
        mem_we    = 1'b1;
        mem_wdata = NODE_SPLIT;
      end
      CMD_WR_LEFT: begin
        mem_we    = 1'b1;
        mem_waddr = left;
        mem_wdata = NODE_FREE;
      end
      CMD_WR_RIGHT: begin
        mem_we    = 1'b1;
        mem_waddr = right;
        mem_wdata = NODE_FREE;
      end
      CMD_WR_ALLOC: begin
        mem_we    = 1'b1;
        mem_wdata = NODE_ALLOC;
      end
      CMD_WR_FREED: begin
        mem_we    = 1'b1;
        mem_wdata = NODE_FREE;
      end
      CMD_WR_NODE_UNUSED: begin
        mem_we    = 1'b1;
      end
      CMD_WR_BUDDY_UNUSED: begin
        mem_we    = 1'b1;
        mem_waddr = buddy;
      end
      CMD_WR_PARENT: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = NODE_FREE;
      end
      CMD_RD_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = scan_q;
      end
      CMD_RD_NODE: begin
        mem_re    = 1'b1;
      end
      CMD_RD_BUDDY: begin
        mem_re    = 1'b1;
        mem_raddr = buddy;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tree_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= node_e'(tree_mem_q[mem_raddr]);
    end
  end

  // Control registers: pool size, clearing index, output valid.
  always_comb begin
    pool_log2_d = pool_log2_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    if (cfg_we_i) begin
      pool_log2_d = cfg_sat;
      clr_d       = '0;
    end else if (cmd == CMD_CLR_STEP) begin
      clr_d = clr_q + NodeW'(1);
    end
    if (cmd == CMD_PUSH) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_log2_q <= PoolLog2Rst;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pool_log2_q <= pool_log2_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers of one request.
  always_ff @(posedge clk_i) begin
    unique case (cmd)
      CMD_LOAD: begin
        op_free_q  <= req_i.opcode;
        size_q     <= req_i.request_size;
        align_q    <= (req_i.alignment == '0) ? SizeW'(1) : req_i.alignment;
        free_off_q <= req_i.free_offset;
      end
      CMD_ROUND: begin
        real_q <= round_val;
        k_q    <= minlog;
      end
      CMD_K_INC: begin
        k_q <= k_q + CfgW'(1);
      end
      CMD_SET_D: begin
        d_q    <= d_new;
        dd_q   <= d_new;
        scan_q <= level_first(d_new);
      end
      CMD_SCAN_INC: begin
        scan_q <= scan_q + NodeW'(1);
      end
      CMD_NEXT_DEPTH: begin
        dd_q   <= dd_q - DepthW'(1);
        scan_q <= level_first(dd_q - DepthW'(1));
      end
      CMD_HIT: begin
        node_q <= scan_q;
      end
      CMD_WR_RIGHT: begin
        node_q <= left;
        dd_q   <= dd_q + DepthW'(1);
      end
      CMD_WR_ALLOC: begin
        res_off_q <= node_off;
        res_st_q  <= RES_OK;
      end
      CMD_FAIL_ALLOC: begin
        res_off_q <= '0;
        res_st_q  <= RES_NO_SPACE;
      end
      CMD_F_INIT: begin
        node_q <= '0;
        dd_q   <= '0;
      end
      CMD_DESCEND: begin
        node_q <= right - NodeW'(!free_off_q[bidx]);
        dd_q   <= dd_q + DepthW'(1);
      end
      CMD_WR_PARENT: begin
        node_q <= parent;
      end
      CMD_FAIL_FREE: begin
        res_off_q <= '0;
        res_st_q  <= RES_BAD_FREE;
      end
      CMD_OK_FREE: begin
        res_off_q <= '0;
        res_st_q  <= RES_OK;
      end
      CMD_PUSH: begin
        out_off_q <= res_off_q;
        out_st_q  <= res_st_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status_o.cfg_we       = cfg_we_i;
    status_o.req_valid    = req_i.valid;
    status_o.op_free      = op_free_q;
    status_o.rem_busy     = rem_busy;
    status_o.k_step       = (k_q < pool_log2_q) && (pow < real_q);
    status_o.k_fail       = pow < real_q;
    status_o.rd_free      = rd_data_q == NODE_FREE;
    status_o.rd_split     = rd_data_q == NODE_SPLIT;
    status_o.rd_alloc     = rd_data_q == NODE_ALLOC;
    status_o.scan_last    = scan_q == last_dd;
    status_o.dd_zero      = dd_q == '0;
    status_o.dd_eq_d      = dd_q == d_q;
    status_o.dd_next_eq_d = (dd_q + DepthW'(1)) == d_q;
    status_o.dd_lt_depth  = dd_q < depth;
    status_o.off_oob      = {1'b0, free_off_q} >= ((OffW + 1)'(1) << pool_log2_q);
    status_o.off_match    = node_off == free_off_q;
    status_o.node_root    = node_q == '0;
    status_o.clr_last     = clr_q == NodeW'(NodeCount - 1);
    status_o.out_busy     = out_valid_q && !rsp_o.ready;
  end

  assign req_i.ready        = ctrl_i.req_ready;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.block_offset = out_off_q;
  assign rsp_o.status       = out_st_q;

endmodule

`default_nettype wire

@@ hdl/bba_ctrl.sv @@
`default_nettype none

module bba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bba_pkg::dp_status_t status_i,
  output bba_pkg::dp_ctrl_t   ctrl_o
);
  import bba_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:     if (status_i.clr_last) state_d = S_IDLE;
      S_IDLE:      if (status_i.req_valid && !status_i.cfg_we) state_d = S_DISPATCH;
      S_DISPATCH:  state_d = status_i.op_free ? S_F_INIT : S_REM_START;
      S_REM_START: state_d = S_REM_WAIT;
      S_REM_WAIT:  if (!status_i.rem_busy) state_d = S_LOG;
      S_LOG: begin
        priority if (status_i.k_step) state_d = S_LOG;
        else if (status_i.k_fail) state_d = S_PUSH;
        else state_d = S_SCAN_RD;
      end
      S_SCAN_RD:   state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        priority if (status_i.rd_free) state_d = status_i.dd_eq_d ? S_ALLOC : S_SPLIT0;
        else if (status_i.scan_last && status_i.dd_zero) state_d = S_PUSH;
        else state_d = S_SCAN_RD;
      end
      S_SPLIT0:    state_d = S_SPLIT1;
      S_SPLIT1:    state_d = S_SPLIT2;
      S_SPLIT2:    state_d = status_i.dd_next_eq_d ? S_ALLOC : S_SPLIT0;
      S_ALLOC:     state_d = S_PUSH;
      S_F_INIT:    state_d = status_i.off_oob ? S_PUSH : S_F_RD;
      S_F_RD:      state_d = S_F_CHK;
      S_F_CHK: begin
        priority if (status_i.rd_split && status_i.dd_lt_depth) state_d = S_F_RD;
        else if (status_i.rd_alloc && status_i.off_match) state_d = S_M_TOP;
        else state_d = S_PUSH;
      end
      S_M_TOP:     state_d = status_i.node_root ? S_PUSH : S_M_CHK;
      S_M_CHK:     state_d = status_i.rd_free ? S_M_W1 : S_PUSH;
      S_M_W1:      state_d = S_M_W2;
      S_M_W2:      state_d = S_M_TOP;
      S_PUSH:      if (!status_i.out_busy) state_d = S_IDLE;
      default:     state_d = S_CLEAR;
    endcase
    if (status_i.cfg_we) begin
      state_d = S_CLEAR;
    end
  end

  always_comb begin
    ctrl_o.cmd       = CMD_NOP;
    ctrl_o.req_ready = 1'b0;
    unique case (state_q)
      S_CLEAR: ctrl_o.cmd = CMD_CLR_STEP;
      S_IDLE: begin
        ctrl_o.req_ready = !status_i.cfg_we;
        if (status_i.req_valid && !status_i.cfg_we) ctrl_o.cmd = CMD_LOAD;
      end
      S_REM_START: ctrl_o.cmd = CMD_REM_START;
      S_REM_WAIT:  if (!status_i.rem_busy) ctrl_o.cmd = CMD_ROUND;
      S_LOG: begin
        priority if (status_i.k_step) ctrl_o.cmd = CMD_K_INC;
        else if (status_i.k_fail) ctrl_o.cmd = CMD_FAIL_ALLOC;
        else ctrl_o.cmd = CMD_SET_D;
      end
      S_SCAN_RD: ctrl_o.cmd = CMD_RD_SCAN;
      S_SCAN_CHK: begin
        priority if (status_i.rd_free) ctrl_o.cmd = CMD_HIT;
        else if (status_i.scan_last && status_i.dd_zero) ctrl_o.cmd = CMD_FAIL_ALLOC;
        else if (status_i.scan_last) ctrl_o.cmd = CMD_NEXT_DEPTH;
        else ctrl_o.cmd = CMD_SCAN_INC;
      end
      S_SPLIT0: ctrl_o.cmd = CMD_WR_SPLIT;
      S_SPLIT1: ctrl_o.cmd = CMD_WR_LEFT;
      S_SPLIT2: ctrl_o.cmd = CMD_WR_RIGHT;
      S_ALLOC:  ctrl_o.cmd = CMD_WR_ALLOC;
      S_F_INIT: ctrl_o.cmd = status_i.off_oob ? CMD_FAIL_FREE : CMD_F_INIT;
      S_F_RD:   ctrl_o.cmd = CMD_RD_NODE;
      S_F_CHK: begin
        priority if (status_i.rd_split && status_i.dd_lt_depth) ctrl_o.cmd = CMD_DESCEND;
        else if (status_i.rd_alloc && status_i.off_match) ctrl_o.cmd = CMD_WR_FREED;
        else ctrl_o.cmd = CMD_FAIL_FREE;
      end
      S_M_TOP: ctrl_o.cmd = status_i.node_root ? CMD_OK_FREE : CMD_RD_BUDDY;
      S_M_CHK: ctrl_o.cmd = status_i.rd_free ? CMD_WR_NODE_UNUSED : CMD_OK_FREE;
      S_M_W1:  ctrl_o.cmd = CMD_WR_BUDDY_UNUSED;
      S_M_W2:  ctrl_o.cmd = CMD_WR_PARENT;
      S_PUSH:  if (!status_i.out_busy) ctrl_o.cmd = CMD_PUSH;
      default: ctrl_o.cmd = CMD_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/buddy_block_allocator_unit.sv @@
// Channel   Dir  Handshake     Payload
// req_i     in   valid/ready   opcode, request_size, alignment, free_offset
// rsp_o     out  valid/ready   block_offset, status
// cfg       in   cfg_we_i      cfg_wdata_i (pool_size_log2)
//
// One request is handled at a time; a transfer on req_i is taken only in the idle state.
// An allocate rounds the size with the remainder unit, sizes the block, reads and checks
// each node scanned and splits by writing parent, left and right child. A free reads and
// checks each level walked down; a merge reads the buddy and writes node, buddy, parent.
// After reset and each configuration write, clearing all tree nodes keeps ready low.
// A result waits in the output register; the next request may start meanwhile, and only
// its own result stalls until rsp_o is drained.
`default_nettype none

module buddy_block_allocator_unit #(
  parameter int unsigned LEVELS = bba_pkg::LevelsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bba_pkg::CfgW-1:0] cfg_wdata_i,
  bba_req_if.sink                  req_i,
  bba_rsp_if.source                rsp_o
);
  import bba_pkg::*;

  // Command and status between the sequencer and the datapath.
  dp_ctrl_t   ctrl;
  dp_status_t status;

  // The sequencer steps through search, split and merge one memory access at a time.
  bba_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // The datapath holds the tree memory, the request registers and the output register.
  bba_datapath #(
    .LEVELS (LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .ctrl_i      (ctrl),
    .status_o    (status)
  );

  // A configuration write restarts the clearing pass, so no request is taken next cycle.
  a_cfg_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !req_i.ready)
    else $error("request accepted right after a configuration write");

  // Only one request is in flight: an accepted transfer drops ready on the next cycle.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second request accepted while one is in progress");

  // Any failed result reports offset zero.
  a_fail_zero_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == RES_NO_SPACE || rsp_o.status == RES_BAD_FREE))
      |-> (rsp_o.block_offset == '0))
    else $error("failed result with nonzero offset");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bba_pkg::*;

  localparam int unsigned Levels = LevelsDef;
  localparam int unsigned NodeNum = (1 << (Levels + 1)) - 1;
  // Bound on the whole run; past it the bench reports a failure and stops.
  localparam longint CycleLimit = 64'd12_000_000;

  typedef struct packed {
    logic            opcode;
    logic [SizeW-1:0] request_size;
    logic [SizeW-1:0] alignment;
    logic [OffW-1:0]  free_offset;
  } request_t;

  typedef struct packed {
    logic [OffW-1:0] block_offset;
    res_e            status;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  buddy_block_allocator_unit #(.LEVELS(Levels)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i(req_ch.sink),
    .rsp_o(rsp_ch.source)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Shadow of the block tree, in heap order, and the active pool size.
  node_e tree_shadow [NodeNum];
  int unsigned pool_log2;
  grant_t grants_due [$];
  logic [OffW-1:0] live_blocks [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold;
  int unsigned mismatches;
  longint cycle_count;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.opcode = 1'b0;
    req_ch.request_size = '0;
    req_ch.alignment = '0;
    req_ch.free_offset = '0;
    rsp_ch.ready = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned depth_used();
    return (Levels < pool_log2) ? Levels : pool_log2;
  endfunction

  function automatic void clear_tree();
    foreach (tree_shadow[i]) tree_shadow[i] = NODE_UNUSED;
    tree_shadow[0] = NODE_FREE;
  endfunction

  function automatic int find_node(int unsigned d, node_e st);
    for (int unsigned i = (1 << d) - 1; i <= (1 << (d + 1)) - 2 && i < NodeNum; i++)
      if (tree_shadow[i] == st) return int'(i);
    return -1;
  endfunction

  function automatic logic [OffW-1:0] offset_of(int unsigned idx, int unsigned d);
    logic [63:0] pos;
    pos = 64'(idx + 1 - (1 << d));
    return OffW'(pos << (pool_log2 - d));
  endfunction

  // Allocation: round to the granule, then to a power of two, then take the
  // first exact fit or split the smallest larger free block down the left side.
  function automatic grant_t predict_alloc(input logic [SizeW-1:0] sz,
                                           input logic [SizeW-1:0] al);
    grant_t g;
    logic [63:0] want, gran;
    int unsigned k, d, node;
    int hit, dd;
    g.block_offset = '0;
    g.status = RES_NO_SPACE;
    want = 64'(sz);
    gran = (al == 0) ? 64'd1 : 64'(al);
    if (want % gran != 0) want = want + gran - (want % gran);
    k = pool_log2 - depth_used();
    while (k < pool_log2 && (64'd1 << k) < want) k++;
    if ((64'd1 << k) < want) return g;
    d = pool_log2 - k;
    hit = find_node(d, NODE_FREE);
    if (hit >= 0) begin
      tree_shadow[hit] = NODE_ALLOC;
      g.block_offset = offset_of(hit, d);
      g.status = RES_OK;
      return g;
    end
    for (dd = int'(d) - 1; dd >= 0; dd--) begin
      hit = find_node(dd, NODE_FREE);
      if (hit >= 0) break;
    end
    if (hit < 0) return g;
    node = hit;
    while (dd < int'(d)) begin
      tree_shadow[node] = NODE_SPLIT;
      tree_shadow[2 * node + 1] = NODE_FREE;
      tree_shadow[2 * node + 2] = NODE_FREE;
      node = 2 * node + 1;
      dd++;
    end
    tree_shadow[node] = NODE_ALLOC;
    g.block_offset = offset_of(node, d);
    g.status = RES_OK;
    return g;
  endfunction

  // Release: walk down by offset bits, then merge free buddies upward.
  function automatic grant_t predict_release(input logic [OffW-1:0] off);
    grant_t g;
    int unsigned node, d, buddy, parent;
    g.block_offset = '0;
    g.status = RES_BAD_FREE;
    node = 0;
    d = 0;
    if ((64'(off) >> pool_log2) != 0) return g;
    while (tree_shadow[node] == NODE_SPLIT && d < depth_used()) begin
      node = 2 * node + 1 + int'((64'(off) >> (pool_log2 - d - 1)) & 1);
      d++;
    end
    if (tree_shadow[node] != NODE_ALLOC || offset_of(node, d) != off) return g;
    tree_shadow[node] = NODE_FREE;
    while (node != 0) begin
      buddy = (node & 1) ? node + 1 : node - 1;
      parent = (node - 1) / 2;
      if (tree_shadow[buddy] != NODE_FREE) break;
      tree_shadow[node] = NODE_UNUSED;
      tree_shadow[buddy] = NODE_UNUSED;
      tree_shadow[parent] = NODE_FREE;
      node = parent;
    end
    g.status = RES_OK;
    return g;
  endfunction

  // Sends one request, keeping track of the offsets handed out so that frees
  // can target live blocks.
  task automatic send_request(input request_t rq);
    grant_t g;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    req_ch.valid <= 1'b1;
    req_ch.opcode <= rq.opcode;
    req_ch.request_size <= rq.request_size;
    req_ch.alignment <= rq.alignment;
    req_ch.free_offset <= rq.free_offset;
    do @(posedge clk_i); while (!req_ch.ready);
    req_ch.valid <= 1'b0;
    if (rq.opcode == 1'b0) g = predict_alloc(rq.request_size, rq.alignment);
    else g = predict_release(rq.free_offset);
    if (rq.opcode == 1'b0 && g.status == RES_OK) live_blocks.push_back(g.block_offset);
    if (rq.opcode == 1'b1 && g.status == RES_OK)
      foreach (live_blocks[i])
        if (live_blocks[i] == rq.free_offset) begin
          live_blocks.delete(i);
          break;
        end
    grants_due.push_back(g);
    // The block is busy after a transfer anyway; waiting for the next clock edge keeps the
    // next request from driving valid again in the same time step.
    @(posedge clk_i);
  endtask

  task automatic alloc_req(input logic [SizeW-1:0] sz, input logic [SizeW-1:0] al);
    send_request('{1'b0, sz, al, OffW'($urandom)});
  endtask

  task automatic free_req(input logic [OffW-1:0] off);
    send_request('{1'b1, SizeW'({$urandom, $urandom}), SizeW'({$urandom, $urandom}), off});
  endtask

  // Waits until every result is back, plus slack for nothing else pending.
  task automatic drain();
    while (grants_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Writes the pool size while idle; the clearing pass follows on its own.
  task automatic set_pool(input logic [CfgW-1:0] v);
    int unsigned s;
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    s = v;
    pool_log2 = (s < 10) ? 10 : (s > 40) ? 40 : s;
    clear_tree();
    live_blocks.delete();
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (grants_due.size() == 0) begin
        report_mismatch("unexpected result", 64'(rsp_ch.status), 64'd0);
      end else begin
        if (rsp_ch.block_offset !== grants_due[0].block_offset)
          report_mismatch("block_offset", 64'(rsp_ch.block_offset),
                          64'(grants_due[0].block_offset));
        if (rsp_ch.status !== grants_due[0].status)
          report_mismatch("status", 64'(rsp_ch.status), 64'(grants_due[0].status));
        void'(grants_due.pop_front());
      end
    end
  end

  // Receiver stall generator; a long hold is counted down here cycle by cycle.
  always @(posedge clk_i) begin
    if (recv_hold != 0) begin
      recv_hold--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Field extremes, zero sizes and granules, too-large requests and bad frees.
  task automatic test_directed();
    alloc_req('0, '0);
    alloc_req('0, '1);
    alloc_req('1, '0);
    alloc_req(41'd1 << 20, '0);
    alloc_req(41'd1 << 19, 41'd3);
    alloc_req(41'd1, 41'd1000);
    alloc_req(41'd1 << 40, 41'd1);
    free_req('1);
    free_req(40'd1 << 20);
    free_req(40'd1);
    while (live_blocks.size() != 0) free_req(live_blocks[0]);
    free_req('0);
    for (int i = 0; i < 5; i++) alloc_req(41'd1 << 19, 41'd0);
    free_req(40'd0);
    free_req(40'd0);
    free_req(40'd1 << 19);
    drain();
  endtask

  task automatic test_pool_sizes();
    set_pool(6'd0);
    for (int i = 0; i < 8; i++) alloc_req(41'($urandom_range(0, 200)), 41'($urandom_range(0, 3)));
    while (live_blocks.size() != 0) free_req(live_blocks[0]);
    set_pool(6'd63);
    alloc_req(41'd1 << 40, 41'd0);
    alloc_req(41'd1, 41'd0);
    alloc_req('1, '1);
    while (live_blocks.size() != 0) free_req(live_blocks[0]);
    set_pool(6'd10);
    drain();
  endtask

  // Mostly allocate/free pairs on live blocks, some noise and frees at or one past a live block.
  task automatic test_random(input int unsigned count);
    logic [63:0] pool;
    int unsigned sh;
    logic [OffW-1:0] off;
    pool = 64'd1 << pool_log2;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          sh = $urandom_range(pool_log2);
          alloc_req(41'($urandom_range(0, 32'hffff_ffff) & ((64'd1 << sh) - 1)),
                    ($urandom_range(3) == 0) ? 41'($urandom_range(0, 7)) : 41'd0);
        end
        4, 5, 6: begin
          if (live_blocks.size() != 0)
            free_req(live_blocks[$urandom_range(live_blocks.size() - 1)]);
          else free_req(40'($urandom) % 40'(pool));
        end
        7: alloc_req(SizeW'({$urandom, $urandom}), SizeW'({$urandom, $urandom}));
        8: free_req(OffW'({$urandom, $urandom}));
        default: begin
          off = (live_blocks.size() != 0) ? live_blocks[0] + 40'(pool_log2 & 1) : '0;
          free_req(off);
        end
      endcase
    end
  endtask

  // Receiver holds off long while requests keep coming, then every live block is freed.
  task automatic test_backpressure();
    recv_hold = 3000;
    for (int i = 0; i < 6; i++) alloc_req(41'd16, 41'd0);
    drain();
    while (live_blocks.size() != 0) free_req(live_blocks[0]);
    drain();
  endtask

  initial begin
    mismatches = 0;
    cycle_count = 0;
    recv_hold = 0;
    pool_log2 = PoolLog2Rst;
    clear_tree();
    send_idle_pct = 10;
    recv_idle_pct = 84;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_pool_sizes();
    test_random(300);
    set_pool(6'd40);
    send_idle_pct = 84;
    recv_idle_pct = 10;
    test_random(300);
    test_backpressure();
    set_pool(6'd16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(300);
    drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && grants_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
